FILE: rtl/scma_pkg.sv
// Package for the sparse column matrix-vector accumulate block.
// Holds codes, reset constants, controller state type and control structs.
// No dependencies.
`default_nettype none

package scma_pkg;

  localparam logic       REQ_ACCUM = 1'b0;
  localparam logic       REQ_READ  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam logic [10:0] VLEN_RESET = 11'd1024;

  localparam logic signed [39:0] ACC_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] ACC_MIN = {1'b1, {39{1'b0}}};

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic fetch;
    logic exec;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/scma_req_if.sv
// Request channel: valid/ready handshake plus one request beat.
// No dependencies.
`default_nettype none

interface scma_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [9:0]         row_index;
  logic signed [15:0] matrix_value;
  logic signed [15:0] column_value;

  modport source (output valid, req_type, row_index, matrix_value, column_value,
                  input ready);
  modport sink   (input valid, req_type, row_index, matrix_value, column_value,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/scma_rsp_if.sv
// Result channel: valid/ready handshake plus one result beat.
// No dependencies.
`default_nettype none

interface scma_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] row_value;
  logic [1:0]         status;

  modport source (output valid, row_value, status, input ready);
  modport sink   (input valid, row_value, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/scma_ctrl.sv
// Controller FSM: clearing pass, request accept, fetch and commit sequencing.
// Depends on scma_pkg.
`default_nettype none

module scma_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire scma_pkg::stat_t stat,
  output scma_pkg::cmd_t      cmd
);
  import scma_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      ST_EXEC: begin
        cmd.exec = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/scma_dp.sv
// Datapath: accumulator memory, length register, multiplier, saturating add,
// result register. Depends on scma_pkg.
`default_nettype none

module scma_dp #(
  parameter int ROW_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire scma_pkg::cmd_t     cmd,
  output scma_pkg::stat_t         stat,
  input  wire logic               cfg_we,
  input  wire logic [10:0]        cfg_wdata,
  input  wire logic               in_type,
  input  wire logic [9:0]         in_row,
  input  wire logic signed [15:0] in_a,
  input  wire logic signed [15:0] in_b,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [39:0]      out_value,
  output logic [1:0]              out_status
);
  import scma_pkg::*;

  localparam int AW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam logic [16:0] DEPTH_W = 17'(ROW_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ROW_DEPTH - 1);

  logic signed [39:0] mem [ROW_DEPTH];

  logic [10:0]        vlen;
  logic [AW-1:0]      clr_cnt;
  logic               r_type;
  logic [9:0]         r_row;
  logic [AW-1:0]      r_addr;
  logic signed [15:0] r_a;
  logic signed [15:0] r_b;
  logic signed [39:0] rd_data;
  logic signed [31:0] prod;
  logic               r_ok;

  logic [AW+9:0]      in_row_ext;
  logic [AW-1:0]      in_addr;
  logic signed [40:0] sum;
  logic signed [39:0] acc_res;
  logic [1:0]         acc_status;
  logic signed [39:0] wr_value;

  assign in_row_ext = {{AW{1'b0}}, in_row};
  assign in_addr    = in_row_ext[AW-1:0];

  assign stat.clr_last = (clr_cnt == LAST_ADDR);
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vlen <= VLEN_RESET;
    end else if (cfg_we) begin
      vlen <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // request capture and memory read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_type  <= in_type;
      r_row   <= in_row;
      r_addr  <= in_addr;
      r_a     <= in_a;
      r_b     <= in_b;
      rd_data <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      prod <= r_a * r_b;
      r_ok <= ({1'b0, r_row} < vlen) && ({7'd0, r_row} < DEPTH_W);
    end
  end

  always_comb begin
    sum = {rd_data[39], rd_data} + {{9{prod[31]}}, prod};
    if (sum[40] != sum[39]) begin
      acc_res    = sum[40] ? ACC_MIN : ACC_MAX;
      acc_status = STATUS_SAT;
    end else begin
      acc_res    = sum[39:0];
      acc_status = STATUS_OK;
    end
    wr_value = (r_type == REQ_READ) ? '0 : acc_res;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_cnt] <= '0;
    end else if (cmd.exec && r_ok) begin
      mem[r_addr] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (!r_ok) begin
        out_value  <= '0;
        out_status <= STATUS_RANGE;
      end else if (r_type == REQ_READ) begin
        out_value  <= rd_data;
        out_status <= STATUS_OK;
      end else begin
        out_value  <= acc_res;
        out_status <= acc_status;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sparse_column_matvec_accumulate.sv
// Scatter-accumulate engine for y = A*x, A stored by compressed columns.
// One request at a time, stepped through accept, multiply and commit; the
// result waits in an output register.
// After rst a clearing pass writes ROW_DEPTH zeros, one per cycle, during
// which no request is accepted; the length register resets to 1024.
// Depends on scma_pkg, scma_req_if, scma_rsp_if, scma_ctrl, scma_dp.
`default_nettype none

module sparse_column_matvec_accumulate #(
  parameter int ROW_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  scma_req_if.sink         req,
  scma_rsp_if.source       rsp
);
  import scma_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  req_ready;
  logic  out_valid;
  logic signed [39:0] out_value;
  logic [1:0]         out_status;

  scma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  scma_dp #(
    .ROW_DEPTH (ROW_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_type    (req.req_type),
    .in_row     (req.row_index),
    .in_a       (req.matrix_value),
    .in_b       (req.column_value),
    .out_valid  (out_valid),
    .out_ready  (rsp.ready),
    .out_value  (out_value),
    .out_status (out_status)
  );

  assign req.ready     = req_ready;
  assign rsp.valid     = out_valid;
  assign rsp.row_value = out_value;
  assign rsp.status    = out_status;

endmodule

`default_nettype wire

FILE: tb/sparse_column_matvec_accumulate_test.sv
// Self-checking testbench for sparse_column_matvec_accumulate: scatter-accumulate
// of Q1.15 products into Q10.30 row sums, row range errors, saturation, read-clear.
// Depends on scma_pkg, scma_req_if, scma_rsp_if and the block itself.
`default_nettype none

module sparse_column_matvec_accumulate_test;
  import scma_pkg::*;

  localparam int ROWS        = 1024;
  localparam int QUIET_LIMIT = 5000;

  typedef struct packed {
    logic signed [39:0] row_value;
    logic [1:0]         status;
  } row_result_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [10:0] cfg_wdata = '0;

  scma_req_if req_ch ();
  scma_rsp_if rsp_ch ();

  sparse_column_matvec_accumulate #(.ROW_DEPTH(ROWS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  logic signed [39:0] row_sums [ROWS];
  logic [10:0]        row_limit;
  row_result_t        expected_rows [$];
  row_result_t        want_row;
  int                 src_idle_pct;
  int                 dst_idle_pct;
  int                 stall_cycles;
  int                 mismatches;
  int                 quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic row_result_t predict_row(input logic kind, input logic [9:0] row,
                                               input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    row_result_t        r;
    logic signed [31:0] prod;
    logic signed [41:0] sum;
    r.row_value = '0;
    r.status    = STATUS_OK;
    if ({1'b0, row} >= row_limit) begin
      r.status = STATUS_RANGE;
    end else if (kind == REQ_READ) begin
      r.row_value   = row_sums[row];
      row_sums[row] = '0;
    end else begin
      prod = a * b;
      sum  = row_sums[row] + prod;
      if (sum > ACC_MAX) begin
        sum      = ACC_MAX;
        r.status = STATUS_SAT;
      end else if (sum < ACC_MIN) begin
        sum      = ACC_MIN;
        r.status = STATUS_SAT;
      end
      row_sums[row] = sum[39:0];
      r.row_value   = sum[39:0];
    end
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic issue_request(input logic kind, input logic [9:0] row,
                               input logic signed [15:0] a, input logic signed [15:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.row_index    <= row;
    req_ch.matrix_value <= a;
    req_ch.column_value <= b;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_rows.push_back(predict_row(kind, row, a, b));
  endtask

  task automatic settle_block();
    req_ch.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_vector_length(input logic [10:0] len);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    row_limit  = len;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_extremes();
    issue_request(REQ_ACCUM, 10'd0, -16'sd32768, -16'sd32768);
    issue_request(REQ_ACCUM, 10'd0, 16'sd32767, 16'sd32767);
    issue_request(REQ_ACCUM, 10'd0, 16'sd32767, -16'sd32768);
    issue_request(REQ_ACCUM, 10'd0, 16'sd0, 16'sd12345);
    issue_request(REQ_READ, 10'd0, 16'($urandom), 16'($urandom));
    issue_request(REQ_READ, 10'd0, 16'hFFFF, 16'hFFFF);
    issue_request(REQ_ACCUM, 10'd1023, -16'sd32768, 16'sd1);
    issue_request(REQ_ACCUM, 10'd1023, 16'sd1, -16'sd1);
    issue_request(REQ_READ, 10'd1023, 16'h0000, 16'h0000);
    issue_request(REQ_READ, 10'd512, 16'($urandom), 16'($urandom));
    issue_request(REQ_ACCUM, 10'h155, 16'h5555, 16'hAAAA);
    issue_request(REQ_ACCUM, 10'h2AA, 16'hAAAA, 16'h5555);
    issue_request(REQ_ACCUM, 10'h2AA, 16'hAAAA, 16'hAAAA);
    issue_request(REQ_READ, 10'h155, 16'($urandom), 16'($urandom));
    issue_request(REQ_READ, 10'h2AA, 16'($urandom), 16'($urandom));
    settle_block();
  endtask

  task automatic test_row_range();
    write_vector_length(11'd1);
    issue_request(REQ_ACCUM, 10'd0, 16'sd1000, 16'sd2000);
    issue_request(REQ_ACCUM, 10'd1, 16'sd1000, 16'sd2000);
    issue_request(REQ_READ, 10'd1, 16'sd0, 16'sd0);
    issue_request(REQ_ACCUM, 10'd1023, 16'sd5, 16'sd5);
    issue_request(REQ_READ, 10'd0, 16'sd0, 16'sd0);
    write_vector_length(11'd0);
    issue_request(REQ_ACCUM, 10'd0, 16'sd7, 16'sd7);
    issue_request(REQ_READ, 10'd0, 16'sd0, 16'sd0);
    write_vector_length(11'd2047);
    issue_request(REQ_ACCUM, 10'd1023, 16'sd300, -16'sd300);
    issue_request(REQ_READ, 10'd1023, 16'sd0, 16'sd0);
    write_vector_length(11'd513);
    issue_request(REQ_ACCUM, 10'd512, 16'sd9, 16'sd9);
    issue_request(REQ_ACCUM, 10'd513, 16'sd9, 16'sd9);
    issue_request(REQ_READ, 10'd512, 16'sd0, 16'sd0);
    write_vector_length(VLEN_RESET);
  endtask

  // +1.0 and just over -1.0 products drive a row past both limits.
  task automatic test_saturation();
    repeat (515) issue_request(REQ_ACCUM, 10'd7, -16'sd32768, -16'sd32768);
    issue_request(REQ_ACCUM, 10'd7, -16'sd32768, 16'sd32767);
    issue_request(REQ_READ, 10'd7, 16'sd0, 16'sd0);
    repeat (515) issue_request(REQ_ACCUM, 10'd7, -16'sd32768, 16'sd32767);
    issue_request(REQ_ACCUM, 10'd7, 16'sd32767, 16'sd32767);
    issue_request(REQ_READ, 10'd7, 16'sd0, 16'sd0);
    settle_block();
  endtask

  task automatic test_output_stall();
    int k;
    stall_cycles <= 400;
    for (k = 0; k < 30; k++) begin
      issue_request(REQ_ACCUM, 10'(100 + (k % 5)), 16'($urandom), 16'($urandom));
    end
    for (k = 0; k < 5; k++) begin
      issue_request(REQ_READ, 10'(100 + k), 16'($urandom), 16'($urandom));
    end
    settle_block();
  endtask

  // Mostly column bursts into a row window, sometimes followed by read-out; some noise.
  task automatic test_random_traffic(input int items, input logic [10:0] len);
    int                 sent;
    int                 n;
    int                 k;
    int                 span;
    int                 base;
    logic signed [15:0] x;
    write_vector_length(len);
    span = (len > ROWS) ? ROWS : len;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 20) begin
        issue_request(1'($urandom), 10'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end else begin
        base = $urandom_range(0, span - 1);
        x    = 16'($urandom);
        n    = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          issue_request(REQ_ACCUM, 10'((base + $urandom_range(0, 15)) % span),
                        16'($urandom), x);
        end
        sent += n;
        if ($urandom_range(3) == 0) begin
          for (k = 0; k < 16; k++) begin
            issue_request(REQ_READ, 10'((base + k) % span), 16'($urandom), 16'($urandom));
          end
          sent += 16;
        end
      end
    end
    settle_block();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rows.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result beat: value %0d status %0d",
                     rsp_ch.row_value, rsp_ch.status);
          end
          mismatches++;
        end else begin
          want_row = expected_rows.pop_front();
          if (rsp_ch.row_value !== want_row.row_value || rsp_ch.status !== want_row.status) begin
            if (mismatches < 10) begin
              $display("result mismatch: expected value %0d status %0d, got value %0d status %0d",
                       want_row.row_value, want_row.status, rsp_ch.row_value, rsp_ch.status);
            end
            mismatches++;
          end
        end
      end
      if (stall_cycles != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_cycles <= stall_cycles - 1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("sparse_column_matvec_accumulate regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_ACCUM;
    req_ch.row_index    = '0;
    req_ch.matrix_value = '0;
    req_ch.column_value = '0;
    rsp_ch.ready        = 1'b0;
    stall_cycles        = 0;
    mismatches          = 0;
    quiet_cycles        = 0;
    row_limit           = VLEN_RESET;
    foreach (row_sums[i]) row_sums[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 38;
    dst_idle_pct = 61;
    test_directed_extremes();
    test_row_range();
    test_saturation();
    test_output_stall();
    test_random_traffic(30, VLEN_RESET);
    src_idle_pct = 61;
    dst_idle_pct = 38;
    test_random_traffic(30, 11'($urandom_range(1, 1023)));
    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_random_traffic(40, 11'($urandom_range(1025, 2047)));

    settle_block();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("sparse_column_matvec_accumulate regression: pass");
    end else begin
      $display("sparse_column_matvec_accumulate regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
